### hdl/dcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types and constants for the distinct color counter.
// ----------------------------------------------------------------------------
package dcc_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TOTAL_W     = 7;
    localparam int ENTRY_W     = 6;
    localparam int COLOR_W     = 32;
    localparam int COUNT_W     = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_FULL = TOTAL_W'(TABLE_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // Function codes on the input channel
    localparam logic FUNC_COUNT = 1'b0;
    localparam logic FUNC_DUMP  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DREAD,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch input color, rewind address
        logic empty_load;  // result for a dump of an empty table
        logic scan;        // read next entry for compare
        logic upd_hit;     // bump matched count, load result
        logic append;      // write new entry, load result
        logic flag_full;   // load dropped-color result
        logic dump_read;   // load result from table at address
        logic dump_next;   // advance dump address
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic func;        // function bit of the offered beat
        logic empty;       // no entries stored
        logic hit;         // compared entry matches
        logic exhausted;   // no more entries to compare
        logic full;        // table holds TABLE_DEPTH entries
        logic res_last;    // result register holds the last beat
    } t_dp_status;

endpackage

### hdl/dcc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_in_if
// Input channel: function code and RGBA color with valid/ready.
// ----------------------------------------------------------------------------
interface dcc_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, output func, output red, output green,
                    output blue, output alpha, input ready);
    modport sink   (input valid, input func, input red, input green,
                    input blue, input alpha, output ready);
endinterface

### hdl/dcc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_out_if
// Result channel: one table entry report per beat with valid/ready.
// ----------------------------------------------------------------------------
interface dcc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic [15:0] occurrences;
    logic [5:0]  entry_index;
    logic        entry_valid;
    logic        table_full;
    logic        last;

    modport source (output valid, output out_red, output out_green,
                    output out_blue, output out_alpha, output occurrences,
                    output entry_index, output entry_valid, output table_full,
                    output last, input ready);
    modport sink   (input valid, input out_red, input out_green,
                    input out_blue, input out_alpha, input occurrences,
                    input entry_index, input entry_valid, input table_full,
                    input last, output ready);
endinterface

### hdl/distinct_color_counter_unit.sv
`timescale 1ns / 1ps
// Count item: accept beat, then up to one compare per stored entry through the single read
// port of the color table, then one result beat (hit, new entry or table-full flag).
// Dump item: one table read plus one result beat per entry; an empty table gives one beat.
// One item in flight; the next item is accepted the cycle after its last result beat.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
// distinct_color_counter_unit
// Counts distinct RGBA colors in a table and reports entries on request.
// ----------------------------------------------------------------------------
module distinct_color_counter_unit
    import dcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcc_in_if.sink    i_in,
    dcc_out_if.source o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;
    logic       out_valid;

    dcc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dcc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_func        (i_in.func),
        .i_red         (i_in.red),
        .i_green       (i_in.green),
        .i_blue        (i_in.blue),
        .i_alpha       (i_in.alpha),
        .o_out_red     (o_out.out_red),
        .o_out_green   (o_out.out_green),
        .o_out_blue    (o_out.out_blue),
        .o_out_alpha   (o_out.out_alpha),
        .o_occurrences (o_out.occurrences),
        .o_entry_index (o_out.entry_index),
        .o_entry_valid (o_out.entry_valid),
        .o_table_full  (o_out.table_full),
        .o_last        (o_out.last)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

### hdl/dcc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_datapath
// Color/count tables, scan address, compare and result register.
// ----------------------------------------------------------------------------
module dcc_datapath
    import dcc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic               i_func,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic [7:0]         i_alpha,
    output logic [7:0]         o_out_red,
    output logic [7:0]         o_out_green,
    output logic [7:0]         o_out_blue,
    output logic [7:0]         o_out_alpha,
    output logic [15:0]        o_occurrences,
    output logic [5:0]         o_entry_index,
    output logic               o_entry_valid,
    output logic               o_table_full,
    output logic               o_last
);

    // Table storage, written and read one address per cycle
    logic [COLOR_W-1:0] color_store [TABLE_DEPTH];
    logic [COUNT_W-1:0] count_store [TABLE_DEPTH];

    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] r_addr;
    logic [COLOR_W-1:0] r_color;
    logic [COLOR_W-1:0] r_rd_color;
    logic [COUNT_W-1:0] r_rd_count;
    logic [ADDR_W-1:0]  r_rd_idx;
    logic               r_rd_vld;

    logic [COLOR_W-1:0] r_res_color;
    logic [COUNT_W-1:0] r_res_count;
    logic [ENTRY_W-1:0] r_res_idx;
    logic               r_res_valid;
    logic               r_res_full;
    logic               r_res_last;

    logic [COUNT_W-1:0] inc_count;
    logic [TOTAL_W-1:0] addr_plus1;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COLOR_W-1:0] wr_color;
    logic [COUNT_W-1:0] wr_count;

    // Saturating increment of the compared count
    assign inc_count  = (r_rd_count == COUNT_MAX) ? r_rd_count : r_rd_count + 1'b1;
    assign addr_plus1 = r_addr + 1'b1;

    // Status back to the controller
    always_comb begin
        o_status.func      = i_func;
        o_status.empty     = (r_total == '0);
        o_status.hit       = r_rd_vld && (r_rd_color == r_color);
        o_status.exhausted = (r_addr >= r_total) && !o_status.hit;
        o_status.full      = (r_total >= TOTAL_FULL);
        o_status.res_last  = r_res_last;
    end

    // Table write port: count bump or new entry
    always_comb begin
        wr_en    = i_cmd.upd_hit || i_cmd.append;
        wr_addr  = i_cmd.upd_hit ? r_rd_idx : r_total[ADDR_W-1:0];
        wr_color = r_color;
        wr_count = i_cmd.upd_hit ? inc_count : COUNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            count_store[wr_addr] <= wr_count;
            if (i_cmd.append) begin
                color_store[wr_addr] <= wr_color;
            end
        end
    end

    // Table read port: scan compare register
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_color <= color_store[r_addr[ADDR_W-1:0]];
            r_rd_count <= count_store[r_addr[ADDR_W-1:0]];
            r_rd_idx   <= r_addr[ADDR_W-1:0];
        end
    end

    // Control registers: entry total, address, read-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                r_total <= r_total + 1'b1;
            end
            if (i_cmd.capture) begin
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_addr   <= addr_plus1;
                r_rd_vld <= (r_addr < r_total);
            end else if (i_cmd.dump_next) begin
                r_addr <= addr_plus1;
            end
        end
    end

    // Input color latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_color <= {i_red, i_green, i_blue, i_alpha};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_last <= 1'b0;
        end else if (i_cmd.empty_load) begin
            r_res_color <= '0;
            r_res_count <= '0;
            r_res_idx   <= '0;
            r_res_valid <= 1'b0;
            r_res_full  <= 1'b0;
            r_res_last  <= 1'b1;
        end else if (i_cmd.upd_hit) begin
            r_res_color <= r_color;
            r_res_count <= inc_count;
            r_res_idx   <= ENTRY_W'(r_rd_idx);
            r_res_valid <= 1'b1;
            r_res_full  <= 1'b0;
            r_res_last  <= 1'b1;
        end else if (i_cmd.append) begin
            r_res_color <= r_color;
            r_res_count <= COUNT_W'(1);
            r_res_idx   <= ENTRY_W'(r_total[ADDR_W-1:0]);
            r_res_valid <= 1'b1;
            r_res_full  <= 1'b0;
            r_res_last  <= 1'b1;
        end else if (i_cmd.flag_full) begin
            r_res_color <= r_color;
            r_res_count <= '0;
            r_res_idx   <= '0;
            r_res_valid <= 1'b0;
            r_res_full  <= 1'b1;
            r_res_last  <= 1'b1;
        end else if (i_cmd.dump_read) begin
            r_res_color <= color_store[r_addr[ADDR_W-1:0]];
            r_res_count <= count_store[r_addr[ADDR_W-1:0]];
            r_res_idx   <= ENTRY_W'(r_addr[ADDR_W-1:0]);
            r_res_valid <= 1'b1;
            r_res_full  <= 1'b0;
            r_res_last  <= (addr_plus1 == r_total);
        end
    end

    assign o_out_red     = r_res_color[31:24];
    assign o_out_green   = r_res_color[23:16];
    assign o_out_blue    = r_res_color[15:8];
    assign o_out_alpha   = r_res_color[7:0];
    assign o_occurrences = r_res_count;
    assign o_entry_index = r_res_idx;
    assign o_entry_valid = r_res_valid;
    assign o_table_full  = r_res_full;
    assign o_last        = r_res_last;

endmodule

### hdl/dcc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_controller
// Sequencer for search, append, dump and result handshake.
// ----------------------------------------------------------------------------
module dcc_controller
    import dcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.func == FUNC_DUMP) begin
                        if (i_status.empty) begin
                            o_cmd.empty_load = 1'b1;
                            n_state          = S_OUT;
                        end else begin
                            n_state = S_DREAD;
                        end
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (i_status.hit) begin
                    o_cmd.upd_hit = 1'b1;
                    n_state       = S_OUT;
                end else if (i_status.exhausted) begin
                    if (i_status.full) begin
                        o_cmd.flag_full = 1'b1;
                    end else begin
                        o_cmd.append = 1'b1;
                    end
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_DREAD: begin
                o_cmd.dump_read = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.dump_next = 1'b1;
                        n_state         = S_DREAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
